/* design/pcc_pkg.sv */
// Shared types, constants and letter tables for the Pali collation compare block.
// Used by pcc_step, pali_collation_compare and the testbench; depends on nothing else.
package pcc_pkg;

    localparam int MAX_LETTERS    = 64;
    localparam int MAX_WORD_BYTES = 256;

    localparam int LCNT_W = $clog2(MAX_LETTERS + 1);
    localparam int IDX_W  = $clog2(MAX_LETTERS);
    localparam int BCNT_W = $clog2(MAX_WORD_BYTES + 1);
    localparam int RANK_W = 6;

    localparam logic [RANK_W-1:0] RANK_UNKNOWN = 6'd41;
    localparam logic [7:0]        BYTE_H       = 8'h68;
    localparam logic [7:0]        CONT_MASK    = 8'hC0;
    localparam logic [7:0]        CONT_CODE    = 8'h80;
    localparam logic [2:0]        CHAR_KEEP    = 3'd3;
    localparam logic [2:0]        CHAR_LEN_MAX = 3'd7;

    typedef enum logic {
        PHASE_OPEN   = 1'b0,
        PHASE_CLOSED = 1'b1
    } pcc_phase_t;

    typedef struct packed {
        pcc_phase_t          phase;
        logic [LCNT_W-1:0]   w1l;
        logic [BCNT_W-1:0]   w1b;
        logic [LCNT_W-1:0]   w2l;
        logic [BCNT_W-1:0]   w2b;
        logic [23:0]         cb;
        logic [2:0]          cl;
        logic                dec;
        logic                decv;
        logic                ov1;
        logic                ov2;
        logic                tail_valid;
        logic [IDX_W-1:0]    tail_idx;
        logic [RANK_W-1:0]   tail_rank;
    } pcc_state_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [RANK_W-1:0]   data;
    } pcc_wr_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic ovf;
    } pcc_result_t;

    // Rank of an assembled character in the 41-letter alphabet.
    function automatic logic [RANK_W-1:0] pcc_char_rank(input logic [2:0] len,
                                                        input logic [23:0] code);
        logic [RANK_W-1:0] r;
        r = RANK_UNKNOWN;
        unique case (len)
            3'd1:
            begin
                case (code)
                    24'h000061: r = 6'd0;
                    24'h000069: r = 6'd2;
                    24'h000075: r = 6'd4;
                    24'h000065: r = 6'd6;
                    24'h00006F: r = 6'd7;
                    24'h00006B: r = 6'd8;
                    24'h000067: r = 6'd10;
                    24'h000063: r = 6'd13;
                    24'h00006A: r = 6'd15;
                    24'h000074: r = 6'd23;
                    24'h000064: r = 6'd25;
                    24'h00006E: r = 6'd27;
                    24'h000070: r = 6'd28;
                    24'h000062: r = 6'd30;
                    24'h00006D: r = 6'd32;
                    24'h000079: r = 6'd33;
                    24'h000072: r = 6'd34;
                    24'h00006C: r = 6'd35;
                    24'h000076: r = 6'd36;
                    24'h000073: r = 6'd37;
                    24'h000068: r = 6'd38;
                    default:    r = RANK_UNKNOWN;
                endcase
            end
            3'd2:
            begin
                case (code)
                    24'h00C481: r = 6'd1;
                    24'h00C4AB: r = 6'd3;
                    24'h00C5AB: r = 6'd5;
                    24'h00C3B1: r = 6'd17;
                    default:    r = RANK_UNKNOWN;
                endcase
            end
            3'd3:
            begin
                case (code)
                    24'hE1B985: r = 6'd12;
                    24'hE1B9AD: r = 6'd18;
                    24'hE1B88D: r = 6'd20;
                    24'hE1B987: r = 6'd22;
                    24'hE1B8B7: r = 6'd39;
                    24'hE1B983: r = 6'd40;
                    default:    r = RANK_UNKNOWN;
                endcase
            end
            default: r = RANK_UNKNOWN;
        endcase
        return r;
    endfunction

    // True for base letters whose aspirated form follows them in the alphabet.
    function automatic logic pcc_mergeable(input logic [RANK_W-1:0] r);
        logic m;
        case (r) inside
            6'd8, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20, 6'd23, 6'd25, 6'd28, 6'd30: m = 1'b1;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

/* design/pali_collation_compare.sv */
// Pali collation compare: the verdict is in the result register in the cycle after the last byte
// of word two. Throughput is one byte per cycle while in_ready is high, set by the combinational
// step logic and the two-read-port rank RAM. A byte is accepted whenever the result register is
// empty or being emptied in that cycle. Reset clears all control state and the result valid flag
// at once; the rank RAM needs no clearing pass, since only current word-one entries are read.
module pali_collation_compare (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       second_word,
    input  logic       last_byte_of_word,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       word_one_first,
    output logic       overflow
);
    import pcc_pkg::*;

    // The state register holds the counters, the character being assembled, the running
    // verdict and the tail letter of word one. Each accepted request updates it.
    pcc_state_t  state_reg;
    pcc_state_t  state_next;
    pcc_state_t  step_state;
    pcc_wr_t     step_wr;
    pcc_result_t step_result;

    logic              accept;
    logic [RANK_W-1:0] ram_a;
    logic [RANK_W-1:0] ram_b;

    logic out_valid_reg;
    logic out_valid_next;
    logic out_first_reg;
    logic out_ovf_reg;

    // A new request is taken as long as the result register can be freed in this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pcc_step u_step (
        .state             (state_reg),
        .data_byte         (data_byte),
        .second_word       (second_word),
        .last_byte_of_word (last_byte_of_word),
        .ram_a             (ram_a),
        .ram_b             (ram_b),
        .state_next        (step_state),
        .wr                (step_wr),
        .result            (step_result)
    );

    assign state_next = accept ? step_state : state_reg;

    // The rank RAM holds word one's letters except one still open as word one closes. The read
    // ports are aimed at the next word-two letter index and the one after it, so both ranks a byte
    // may need are waiting in the read registers when that byte arrives.
    pcc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_LETTERS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (accept && step_wr.en),
        .wr_addr   (step_wr.addr),
        .wr_data   (step_wr.data),
        .rd_addr_a (state_next.w2l[IDX_W-1:0]),
        .rd_data_a (ram_a),
        .rd_addr_b (state_next.w2l[IDX_W-1:0] + IDX_W'(1)),
        .rd_data_b (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result register: loaded with the verdict on the last byte of word two.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && step_result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_result.valid)
        begin
            out_first_reg <= step_result.first;
            out_ovf_reg   <= step_result.ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_one_first = out_first_reg;
    assign overflow       = out_ovf_reg;

`ifndef SYNTH
    // The tail letter is only ever recorded when word one closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tail_valid |-> state_reg.phase == PHASE_CLOSED)
        else $error("tail letter valid while word one is open");

    // Letter counters never run past the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.w1l <= LCNT_W'(MAX_LETTERS)) && (state_reg.w2l <= LCNT_W'(MAX_LETTERS)))
        else $error("letter count beyond capacity");

    // Ranks are written to the RAM only by word-one requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_wr.en) |-> !second_word)
        else $error("rank RAM written outside word one");

    // A verdict leaves word two cleared for the next comparison.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && second_word && last_byte_of_word)
        |=> (state_reg.w2l == '0 && state_reg.w2b == '0 && !state_reg.dec && out_valid_reg))
        else $error("word two state not cleared after verdict");
`endif

endmodule

/* design/pcc_ram.sv */
// Generic RAM with one write port and two registered read ports.
// New data is returned when a read address matches the write address. No dependencies.
module pcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
        rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
    end

endmodule

/* design/pcc_step.sv */
// Next-state logic for one accepted byte: character assembly, ranking, storing and comparing.
// Depends on pcc_pkg.
module pcc_step (
    input  pcc_pkg::pcc_state_t      state,
    input  logic [7:0]               data_byte,
    input  logic                     second_word,
    input  logic                     last_byte_of_word,
    input  logic [pcc_pkg::RANK_W-1:0] ram_a,
    input  logic [pcc_pkg::RANK_W-1:0] ram_b,
    output pcc_pkg::pcc_state_t      state_next,
    output pcc_pkg::pcc_wr_t         wr,
    output pcc_pkg::pcc_result_t     result
);
    import pcc_pkg::*;

    localparam logic [LCNT_W-1:0] LETTER_CAP = LCNT_W'(MAX_LETTERS);
    localparam logic [BCNT_W-1:0] BYTE_CAP   = BCNT_W'(MAX_WORD_BYTES);

    logic [RANK_W-1:0] rank_cur;

    assign rank_cur = pcc_char_rank(state.cl, state.cb);

    // Returns the updated {decided, decided_value} after comparing one letter pair.
    function automatic logic [1:0] cmp(input logic [RANK_W-1:0] sv,
                                       input logic [RANK_W-1:0] r,
                                       input logic dec,
                                       input logic decv);
        logic [1:0] o;
        o = {dec, decv};
        if (sv < r)
        begin
            o = 2'b11;
        end
        else if (sv > r)
        begin
            o = 2'b10;
        end
        return o;
    endfunction

    always_comb
    begin
        pcc_state_t        s;
        logic              cont;
        logic              take_valid;
        logic              merged;
        logic [RANK_W-1:0] take_rank;
        logic [RANK_W-1:0] flush_rank;
        logic [RANK_W-1:0] stored_a;
        logic [RANK_W-1:0] stored_b;
        logic [IDX_W-1:0]  idx_b;

        s          = state;
        wr         = '0;
        result     = '0;
        take_valid = 1'b0;
        merged     = 1'b0;
        take_rank  = rank_cur;
        flush_rank = '0;

        if (!second_word && s.phase == PHASE_CLOSED)
        begin
            // A word-one byte after word one was closed starts a new pair.
            s       = '0;
            s.phase = PHASE_OPEN;
        end
        else if (second_word && s.phase == PHASE_OPEN)
        begin
            // Close word one; its last open character goes to the tail register.
            if (s.cl != 3'd0)
            begin
                if (s.w1l < LETTER_CAP)
                begin
                    s.tail_valid = 1'b1;
                    s.tail_idx   = s.w1l[IDX_W-1:0];
                    s.tail_rank  = rank_cur;
                    s.w1l        = s.w1l + LCNT_W'(1);
                end
                else
                begin
                    s.ov1 = 1'b1;
                end
            end
            s.cl    = 3'd0;
            s.cb    = '0;
            s.phase = PHASE_CLOSED;
        end

        // A letter still open when word one closes lives in the tail register, not the RAM.
        idx_b    = s.w2l[IDX_W-1:0] + IDX_W'(1);
        stored_a = (s.tail_valid && s.tail_idx == s.w2l[IDX_W-1:0]) ? s.tail_rank : ram_a;
        stored_b = (s.tail_valid && s.tail_idx == idx_b) ? s.tail_rank : ram_b;

        if (!second_word)
        begin
            if (s.w1b < BYTE_CAP)
            begin
                s.w1b = s.w1b + BCNT_W'(1);
            end
            else
            begin
                s.ov1 = 1'b1;
            end
        end
        else
        begin
            if (s.w2b < BYTE_CAP)
            begin
                s.w2b = s.w2b + BCNT_W'(1);
            end
            else
            begin
                s.ov2 = 1'b1;
            end
        end

        cont = (data_byte & CONT_MASK) == CONT_CODE;
        if (s.cl != 3'd0 && cont)
        begin
            if (s.cl < CHAR_KEEP)
            begin
                s.cb = {s.cb[15:0], data_byte};
            end
            if (s.cl < CHAR_LEN_MAX)
            begin
                s.cl = s.cl + 3'd1;
            end
        end
        else
        begin
            if (s.cl != 3'd0)
            begin
                take_valid = 1'b1;
                if (data_byte == BYTE_H && pcc_mergeable(rank_cur))
                begin
                    take_rank = rank_cur + RANK_W'(1);
                    merged    = 1'b1;
                end
            end
            if (merged)
            begin
                s.cl = 3'd0;
                s.cb = '0;
            end
            else
            begin
                s.cb = {16'd0, data_byte};
                s.cl = 3'd1;
            end
        end

        if (take_valid)
        begin
            if (!second_word)
            begin
                if (s.w1l < LETTER_CAP)
                begin
                    wr.en   = 1'b1;
                    wr.addr = s.w1l[IDX_W-1:0];
                    wr.data = take_rank;
                    s.w1l   = s.w1l + LCNT_W'(1);
                end
                else
                begin
                    s.ov1 = 1'b1;
                end
            end
            else
            begin
                if (s.w2l < LETTER_CAP)
                begin
                    if (!s.dec && s.w2l < s.w1l)
                    begin
                        {s.dec, s.decv} = cmp(stored_a, take_rank, s.dec, s.decv);
                    end
                    s.w2l = s.w2l + LCNT_W'(1);
                end
                else
                begin
                    s.ov2 = 1'b1;
                end
            end
        end

        if (last_byte_of_word)
        begin
            if (s.cl != 3'd0)
            begin
                flush_rank = pcc_char_rank(s.cl, s.cb);
                if (!second_word)
                begin
                    if (s.w1l < LETTER_CAP)
                    begin
                        s.tail_valid = 1'b1;
                        s.tail_idx   = s.w1l[IDX_W-1:0];
                        s.tail_rank  = flush_rank;
                        s.w1l        = s.w1l + LCNT_W'(1);
                    end
                    else
                    begin
                        s.ov1 = 1'b1;
                    end
                end
                else
                begin
                    if (s.w2l < LETTER_CAP)
                    begin
                        if (!s.dec && s.w2l < s.w1l)
                        begin
                            {s.dec, s.decv} = cmp(take_valid ? stored_b : stored_a,
                                                  flush_rank, s.dec, s.decv);
                        end
                        s.w2l = s.w2l + LCNT_W'(1);
                    end
                    else
                    begin
                        s.ov2 = 1'b1;
                    end
                end
            end
            s.cl = 3'd0;
            s.cb = '0;

            if (!second_word)
            begin
                s.phase = PHASE_CLOSED;
            end
            else
            begin
                result.valid = 1'b1;
                result.first = s.dec ? s.decv : (s.w1b < s.w2b);
                result.ovf   = s.ov1 | s.ov2;
                // Word two is cleared right away so the next word two starts fresh.
                s.w2l  = '0;
                s.w2b  = '0;
                s.dec  = 1'b0;
                s.decv = 1'b0;
                s.ov2  = 1'b0;
            end
        end

        state_next = s;
    end

endmodule

/* test/testbench.sv */
// Self-checking testbench for pali_collation_compare: streams UTF-8 word pairs and checks
// every verdict against a built-in predictor of the collation rules.
// Depends on pcc_pkg and the pali_collation_compare RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam int ITEM_TARGET  = 1625;
    localparam int HOLD_CYCLES  = 300;
    localparam int LETTER_COUNT = 41;
    localparam int TAIL_CYCLES  = 20;

    // Word tokens: an alphabet index below LETTER_COUNT, a raw byte at TOK_RAW and above,
    // or a lead byte with a run of continuation bytes at TOK_LONG and above.
    localparam int TOK_RAW  = 256;
    localparam int TOK_LONG = 1 << 20;

    // Where the current pair stands: word one still open, word one closed, verdict given.
    typedef enum logic [1:0] {
        PAIR_OPEN,
        PAIR_CLOSED,
        PAIR_JUDGED
    } pair_stage_t;

    // How the result side paces its ready.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } ready_mode_t;

    typedef struct {
        logic [7:0] data;
        logic       w2;
        logic       last;
    } byte_req_t;

    typedef struct {
        logic first;
        logic ovf;
    } verdict_t;

    // Clock, reset and block ports.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       second_word = 1'b0;
    logic       last_byte_of_word = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       word_one_first;
    logic       overflow;

    // Requests waiting to be offered, and verdicts the block still owes us.
    byte_req_t pending[$];
    verdict_t  verdicts_due[$];

    // Predictor state: a private copy of everything the block remembers.
    logic [RANK_W-1:0] held_ranks [MAX_LETTERS];
    int                one_letters = 0;
    int                one_bytes = 0;
    int                two_letters = 0;
    int                two_bytes = 0;
    logic [23:0]       char_code = '0;
    int                char_len = 0;
    logic              decided_q = 1'b0;
    logic              decided_first = 1'b0;
    logic              one_ovf = 1'b0;
    logic              two_ovf = 1'b0;
    pair_stage_t       stage = PAIR_OPEN;

    // Stimulus scratch: token lists of the two words and the bytes that spell one of them.
    int         toks_one[$];
    int         toks_two[$];
    logic [7:0] spell[$];

    // Bookkeeping shared between the driver, the monitor and the run control.
    int requests_total = 0;
    int requests_accepted = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int cycle_limit = 1000000;

    pali_collation_compare uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .second_word       (second_word),
        .last_byte_of_word (last_byte_of_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .word_one_first    (word_one_first),
        .overflow          (overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Alphabet and predictor
    // ------------------------------------------------------------------

    // Byte count and code of each alphabet letter in sort order. A count of zero marks
    // an aspirated letter, which only arises from its base letter followed by 'h'.
    function automatic logic [26:0] alpha_entry(input int idx);
        logic [26:0] e;
        case (idx)
            0:       e = {3'd1, 24'h000061};
            1:       e = {3'd2, 24'h00C481};
            2:       e = {3'd1, 24'h000069};
            3:       e = {3'd2, 24'h00C4AB};
            4:       e = {3'd1, 24'h000075};
            5:       e = {3'd2, 24'h00C5AB};
            6:       e = {3'd1, 24'h000065};
            7:       e = {3'd1, 24'h00006F};
            8:       e = {3'd1, 24'h00006B};
            10:      e = {3'd1, 24'h000067};
            12:      e = {3'd3, 24'hE1B985};
            13:      e = {3'd1, 24'h000063};
            15:      e = {3'd1, 24'h00006A};
            17:      e = {3'd2, 24'h00C3B1};
            18:      e = {3'd3, 24'hE1B9AD};
            20:      e = {3'd3, 24'hE1B88D};
            22:      e = {3'd3, 24'hE1B987};
            23:      e = {3'd1, 24'h000074};
            25:      e = {3'd1, 24'h000064};
            27:      e = {3'd1, 24'h00006E};
            28:      e = {3'd1, 24'h000070};
            30:      e = {3'd1, 24'h000062};
            32:      e = {3'd1, 24'h00006D};
            33:      e = {3'd1, 24'h000079};
            34:      e = {3'd1, 24'h000072};
            35:      e = {3'd1, 24'h00006C};
            36:      e = {3'd1, 24'h000076};
            37:      e = {3'd1, 24'h000073};
            38:      e = {3'd1, 24'h000068};
            39:      e = {3'd3, 24'hE1B8B7};
            40:      e = {3'd3, 24'hE1B983};
            default: e = '0;
        endcase
        return e;
    endfunction

    // Rank of the character now being assembled; anything not in the alphabet,
    // including a character of more than three bytes, ranks as unknown.
    function automatic logic [RANK_W-1:0] held_rank();
        logic [RANK_W-1:0] r;
        logic [26:0]       e;
        r = RANK_UNKNOWN;
        if (char_len >= 1 && char_len <= 3)
        begin
            for (int i = 0; i < LETTER_COUNT; i++)
            begin
                e = alpha_entry(i);
                if (r == RANK_UNKNOWN && e[26:24] == 3'(char_len) && e[23:0] == char_code)
                    r = RANK_W'(i);
            end
        end
        return r;
    endfunction

    // Word one stores its ranks; word two compares against them until one differs.
    // Letters beyond the rank store are dropped and flag overflow.
    task automatic file_letter(input logic w2, input logic [RANK_W-1:0] r);
        if (!w2)
        begin
            if (one_letters < MAX_LETTERS)
            begin
                held_ranks[one_letters] = r;
                one_letters++;
            end
            else
                one_ovf = 1'b1;
        end
        else
        begin
            if (two_letters < MAX_LETTERS)
            begin
                if (!decided_q && two_letters < one_letters)
                begin
                    if (held_ranks[two_letters] < r)
                    begin
                        decided_q = 1'b1;
                        decided_first = 1'b1;
                    end
                    else if (held_ranks[two_letters] > r)
                    begin
                        decided_q = 1'b1;
                        decided_first = 1'b0;
                    end
                end
                two_letters++;
            end
            else
                two_ovf = 1'b1;
        end
    endtask

    task automatic close_char(input logic w2);
        if (char_len > 0)
            file_letter(w2, held_rank());
        char_len = 0;
        char_code = '0;
    endtask

    task automatic clear_second();
        two_letters = 0;
        two_bytes = 0;
        decided_q = 1'b0;
        decided_first = 1'b0;
        two_ovf = 1'b0;
        char_len = 0;
        char_code = '0;
    endtask

    // Advances the predictor by one accepted request and queues a verdict when the
    // request ends word two.
    task automatic judge_byte(input byte_req_t q);
        logic [RANK_W-1:0] r;
        logic [26:0]       e;
        logic              aspirate;
        verdict_t          v;
        aspirate = 1'b0;

        if (!q.w2)
        begin
            // A word-one byte after word one was closed begins a brand new pair.
            if (stage != PAIR_OPEN)
            begin
                one_letters = 0;
                one_bytes = 0;
                one_ovf = 1'b0;
                clear_second();
                stage = PAIR_OPEN;
            end
            if (one_bytes < MAX_WORD_BYTES)
                one_bytes++;
            else
                one_ovf = 1'b1;
        end
        else
        begin
            // Word two closes an open word one (possibly empty); after a verdict it
            // starts over against the same stored word one.
            if (stage == PAIR_OPEN)
            begin
                close_char(1'b0);
                stage = PAIR_CLOSED;
            end
            else if (stage == PAIR_JUDGED)
            begin
                clear_second();
                stage = PAIR_CLOSED;
            end
            if (two_bytes < MAX_WORD_BYTES)
                two_bytes++;
            else
                two_ovf = 1'b1;
        end

        if (char_len > 0 && (q.data & CONT_MASK) == CONT_CODE)
        begin
            // Continuation byte: only the first three bytes are kept, the length saturates.
            if (char_len < 3)
                char_code = {char_code[15:0], q.data};
            if (char_len < 7)
                char_len++;
        end
        else
        begin
            if (char_len > 0)
            begin
                r = held_rank();
                e = alpha_entry(int'(r) + 1);
                aspirate = (q.data == BYTE_H) && (r < 6'd40) && (e[26:24] == 3'd0);
                file_letter(q.w2, aspirate ? r + 6'd1 : r);
            end
            if (aspirate)
            begin
                char_len = 0;
                char_code = '0;
            end
            else
            begin
                char_code = {16'h0000, q.data};
                char_len = 1;
            end
        end

        if (q.last)
        begin
            close_char(q.w2);
            if (!q.w2)
                stage = PAIR_CLOSED;
            else
            begin
                v.first = decided_q ? decided_first : (one_bytes < two_bytes);
                v.ovf = one_ovf || two_ovf;
                verdicts_due.insert(verdicts_due.size(), v);
                stage = PAIR_JUDGED;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic push_req(input logic [7:0] b, input logic w2, input logic last);
        byte_req_t q;
        q.data = b;
        q.w2 = w2;
        q.last = last;
        pending.insert(pending.size(), q);
    endtask

    // Pushes the n low bytes of s, most significant first, as one complete word.
    task automatic push_string(input logic [95:0] s, input int n, input logic w2);
        for (int i = n - 1; i >= 0; i--)
            push_req(s[8*i +: 8], w2, i == 0);
    endtask

    // Mostly real letters, some raw bytes of any value, some multi-byte runs that are
    // usually unknown and often longer than three bytes.
    function automatic int pick_token();
        int roll;
        roll = int'($urandom_range(0, 19));
        if (roll < 16)
            return int'($urandom_range(0, LETTER_COUNT - 1));
        if (roll < 18)
            return TOK_RAW + int'($urandom_range(0, 255));
        return TOK_LONG + (int'($urandom_range(1, 8)) << 8)
               + (int'($urandom_range(0, 63)) << 12) + int'($urandom_range(0, 63));
    endfunction

    task automatic spell_token(input int tok);
        logic [26:0] e;
        logic        aspirated;
        int          n;
        aspirated = 1'b0;
        if (tok >= TOK_LONG)
        begin
            n = (tok >> 8) & 15;
            spell.insert(spell.size(), {2'b11, tok[5:0]});
            repeat (n)
                spell.insert(spell.size(), {2'b10, tok[17:12]});
        end
        else if (tok >= TOK_RAW)
            spell.insert(spell.size(), tok[7:0]);
        else
        begin
            e = alpha_entry(tok);
            if (e[26:24] == 3'd0)
            begin
                e = alpha_entry(tok - 1);
                aspirated = 1'b1;
            end
            if (e[26:24] >= 3'd3)
                spell.insert(spell.size(), e[23:16]);
            if (e[26:24] >= 3'd2)
                spell.insert(spell.size(), e[15:8]);
            spell.insert(spell.size(), e[7:0]);
            if (aspirated)
                spell.insert(spell.size(), BYTE_H);
        end
    endtask

    // Queues the bytes of word one or word two; the final byte carries the end mark
    // only when with_last is set.
    task automatic emit_word(input logic w2, input logic with_last);
        spell.delete();
        if (w2)
        begin
            foreach (toks_two[i])
                spell_token(toks_two[i]);
        end
        else
        begin
            foreach (toks_one[i])
                spell_token(toks_one[i]);
        end
        foreach (spell[i])
            push_req(spell[i], w2, with_last && (i == spell.size() - 1));
    endtask

    task automatic random_word_one(input int n);
        toks_one.delete();
        repeat (n)
            toks_one.insert(toks_one.size(), pick_token());
    endtask

    // Word two is mostly a near copy of word one so that comparisons run deep:
    // identical, cut short, extended, or with one token swapped.
    task automatic derive_word_two();
        int roll;
        roll = int'($urandom_range(0, 5));
        toks_two = toks_one;
        case (roll)
            0:
            begin
                toks_two.delete();
                repeat ($urandom_range(1, 10))
                    toks_two.insert(toks_two.size(), pick_token());
            end
            2:
            begin
                if (toks_two.size() > 1)
                    repeat ($urandom_range(1, toks_two.size() - 1))
                        void'(toks_two.pop_back());
            end
            3:
            begin
                repeat ($urandom_range(1, 3))
                    toks_two.insert(toks_two.size(), pick_token());
            end
            4:
            begin
                if (toks_two.size() > 0)
                    toks_two[$urandom_range(0, toks_two.size() - 1)] = pick_token();
            end
            default:
            begin
            end
        endcase
        if (toks_two.size() == 0)
            toks_two.insert(toks_two.size(), pick_token());
    endtask

    // A pair aimed at capacity: either a letter count close to or past what the rank store holds,
    // or more bytes than the byte counters take (long runs of continuation bytes).
    task automatic big_pair(input logic by_bytes);
        toks_one.delete();
        if (by_bytes)
            repeat ($urandom_range(33, 38))
                toks_one.insert(toks_one.size(),
                                TOK_LONG + (int'($urandom_range(7, 8)) << 8)
                                + (int'($urandom_range(0, 63)) << 12)
                                + int'($urandom_range(0, 63)));
        else
            repeat ($urandom_range(60, 72))
                toks_one.insert(toks_one.size(), int'($urandom_range(0, LETTER_COUNT - 1)));
        emit_word(1'b0, 1'b1);
        derive_word_two();
        emit_word(1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests in bursts separated by random gaps. The predictor
    // is advanced at the edge where a request is accepted.
    // ------------------------------------------------------------------
    byte_req_t offered;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                judge_byte(offered);
                requests_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    offered = pending.pop_front();
                    data_byte <= offered.data;
                    second_word <= offered.w2;
                    last_byte_of_word <= offered.last;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // New burst; a fifth of the time it follows back to back.
                        burst_left = int'($urandom_range(1, 60));
                        gap_left = ($urandom_range(0, 4) == 0) ? 0
                                   : int'($urandom_range(1, 6));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted verdict against the oldest prediction and paces
    // out_ready. Every so often it holds out_ready low so the pending verdict
    // backs up into the request side while the driver keeps offering.
    // ------------------------------------------------------------------
    verdict_t    want;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          holdoff_left = 0;
    int          next_holdoff = 8;
    int          verdicts_seen = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict: first=%0b overflow=%0b",
                                 word_one_first, overflow);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (want.first !== word_one_first || want.ovf !== overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict %0d: expected %0b/%0b, got %0b/%0b (first/ovf)",
                                     verdicts_seen, want.first, want.ovf,
                                     word_one_first, overflow);
                    end
                end
            end

            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else if (verdicts_seen >= next_holdoff)
            begin
                holdoff_left = HOLD_CYCLES;
                next_holdoff += 40;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = ready_mode_t'($urandom_range(0, 2));
                    mode_left = int'($urandom_range(20, 200));
                end
                else
                    mode_left--;
                case (ready_mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count > cycle_limit);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int roll;

        // Word two straight after reset: word one is empty, so it sorts first.
        push_req(8'h61, 1'b1, 1'b1);
        // Word one: "kh", dotted "th", a stray continuation byte right after the merged
        // 'h', then a five-byte character that ranks as unknown.
        push_string(96'h6B68E1B9AD6880F09F9880BF, 12, 1'b0);
        // Word two with the same ranks via the byte extremes 0x00 and 0xFF; the tie is
        // broken by byte count, and word two is shorter.
        push_string(96'h6B68E1B9AD6800FF, 8, 1'b1);
        // Another word two against the same word one, decided on the first letter.
        push_req(8'h61, 1'b1, 1'b1);
        // New pair whose word one is closed by the first byte of word two.
        push_req(8'h6B, 1'b0, 1'b0);
        push_string(96'h6B68, 2, 1'b1);

        // Pairs aimed at both capacity limits.
        big_pair(1'b0);
        big_pair(1'b1);

        while (pending.size() < ITEM_TARGET)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 60)
            begin
                // Well-formed pair, often with several word twos against one word one.
                random_word_one(int'($urandom_range(1, 8)));
                emit_word(1'b0, 1'b1);
                repeat ($urandom_range(1, 3))
                begin
                    derive_word_two();
                    emit_word(1'b1, 1'b1);
                end
            end
            else if (roll < 70)
            begin
                // Word one never marked as ended; word two closes it.
                random_word_one(int'($urandom_range(0, 8)));
                emit_word(1'b0, 1'b0);
                derive_word_two();
                emit_word(1'b1, 1'b1);
            end
            else if (roll < 78)
            begin
                // Word two abandoned part way; the next word one starts a fresh pair.
                random_word_one(int'($urandom_range(1, 8)));
                emit_word(1'b0, 1'b1);
                derive_word_two();
                emit_word(1'b1, 1'b0);
            end
            else if (roll < 80)
                big_pair(1'($urandom_range(0, 1)));
            else
            begin
                // Noise: any byte, either word, end marks at random.
                repeat ($urandom_range(1, 12))
                    push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0);
            end
        end

        requests_total = pending.size();
        cycle_limit = 100 * requests_total + 20000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_accepted < requests_total)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
